>>> sv/upo_pkg.sv
// shared types and constants for the parking occupancy block
package upo_pkg;
    localparam int WINDOW_MAX_DEF = 16;
    localparam int SENSE_RST = 10;
    localparam int THR_RST = 100;
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [5:0] DIST_NUM = 6'd5;
    localparam logic [5:0] DIST_DEN = 6'd34;

    localparam logic REG_SENSE = 1'b0;
    localparam logic REG_THR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SORT,
        ST_SUM,
        ST_DIV,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_odd;
        logic sort_en;
    } cell_ctl_t;
endpackage

>>> sv/upo_cell.sv
// one cell of the sorting row: holds one reading and swaps with its right neighbor
module upo_cell (
    input  logic           clk,
    input  upo_pkg::cell_ctl_t ctl,
    input  logic           my_odd,
    input  logic [15:0]    load_val,
    input  logic           load_valid,
    input  logic [15:0]    left_val,
    input  logic           left_valid,
    input  logic [15:0]    right_val,
    input  logic           right_valid,
    input  logic           has_right,
    output logic [15:0]    val,
    output logic           valid
);
    logic [15:0] val_reg, val_next;
    logic        valid_reg, valid_next;
    logic        lead, follow;

    // a cell leads a pair when its parity matches the phase
    assign lead   = (my_odd == ctl.sort_odd) && has_right;
    assign follow = (my_odd != ctl.sort_odd);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctl.load)
        begin
            val_next   = load_val;
            valid_next = load_valid;
        end
        else if (ctl.sort_en)
        begin
            // invalid entries sort as largest
            if (lead && valid_reg && right_valid && (val_reg > right_val))
                val_next = right_val;
            else if (lead && !valid_reg && right_valid)
            begin
                val_next   = right_val;
                valid_next = 1'b1;
            end
            else if (follow && left_valid && valid_reg && (left_val > val_reg))
                val_next = left_val;
            else if (follow && !left_valid && valid_reg)
            begin
                valid_next = 1'b0;
                val_next   = left_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        valid_reg <= valid_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;
endmodule

>>> sv/upo_row.sv
// row of sorting cells, odd-even transposition
module upo_row #(
    parameter int WINDOW_MAX = upo_pkg::WINDOW_MAX_DEF
) (
    input  logic                          clk,
    input  upo_pkg::cell_ctl_t            ctl,
    input  logic [WINDOW_MAX-1:0][15:0]   load_val,
    input  logic [WINDOW_MAX-1:0]         load_valid,
    output logic [WINDOW_MAX-1:0][15:0]   vals
);
    logic [WINDOW_MAX-1:0] valids;

    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        logic [15:0] lv, rv;
        logic        lvd, rvd;
        if (g == 0)
        begin : g_l0
            assign lv = 16'd0;
            assign lvd = 1'b1;
        end
        else
        begin : g_l
            assign lv = vals[g-1];
            assign lvd = valids[g-1];
        end
        if (g == WINDOW_MAX - 1)
        begin : g_r0
            assign rv = 16'd0;
            assign rvd = 1'b0;
        end
        else
        begin : g_r
            assign rv = vals[g+1];
            assign rvd = valids[g+1];
        end
        upo_cell u_cell (
            .clk(clk), .ctl(ctl), .my_odd(1'(g % 2)),
            .load_val(load_val[g]), .load_valid(load_valid[g]),
            .left_val(lv), .left_valid(lvd),
            .right_val(rv), .right_valid(rvd),
            .has_right(g != WINDOW_MAX - 1),
            .val(vals[g]), .valid(valids[g])
        );
    end
endmodule

>>> sv/ultrasonic_parking_occupancy.sv
// top level of the ultrasonic parking occupancy detector
//
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tdata[31:0] = byte0, byte1, byte2, byte3
//  m_axis  | out | tvalid/tready     | tdata[15:0] filtered_raw, tuser[3:0] flags
//  cfg     | in  | cfg_we            | cfg_index 0 sense_times, 1 threshold_cm
//
// a request passes through a push, the load and odd-even passes in the cell row,
// the adds of the kept readings, a restoring divide of the sum (SW = 16 + count bits),
// the compare phases on the multipliers shared by the current and previous window
// and the output register.
// reset clears counts, previous value and the control fsm; the window holds
// garbage until written. the result sits in an output register; a new request
// is taken once that register is free.
module ultrasonic_parking_occupancy #(
    parameter int WINDOW_MAX = upo_pkg::WINDOW_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // byte0, byte1, byte2, byte3
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // filtered_raw
    output logic [3:0]  m_axis_tuser,   // frame_ok, window_full, state_changed, occupied
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 16 + CW;
    localparam int LW = $clog2(WINDOW_MAX + SW + 2);
    localparam int DW = $clog2(SW);
    localparam int RW = 20 + CW;
    localparam int TW = CW + 7;

    // compare outcome codes
    localparam logic [1:0] CMP_EQ    = 2'd0;
    localparam logic [1:0] CMP_BELOW = 2'd1;
    localparam logic [1:0] CMP_ABOVE = 2'd2;

    // configuration
    logic [4:0]  sense_reg;
    logic [13:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_reg <= 5'(upo_pkg::SENSE_RST);
            thr_reg   <= 14'(upo_pkg::THR_RST);
        end
        else if (cfg_we)
        begin
            if (cfg_index == upo_pkg::REG_SENSE)
                sense_reg <= cfg_data[4:0];
            else
                thr_reg <= cfg_data;
        end
    end

    // effective window length
    logic [CW-1:0] eff_len;
    always_comb
    begin
        if (sense_reg == 5'd0)
            eff_len = CW'(1);
        else if (32'(sense_reg) > WINDOW_MAX)
            eff_len = CW'(WINDOW_MAX);
        else
            eff_len = CW'(sense_reg);
    end

    // frame decode
    logic [7:0] b0, b1, b2, b3, hi, lo, ck;
    assign b0 = s_axis_tdata[7:0];
    assign b1 = s_axis_tdata[15:8];
    assign b2 = s_axis_tdata[23:16];
    assign b3 = s_axis_tdata[31:24];
    assign hi = (b0 != upo_pkg::HDR_BYTE) ? b0 : b1;
    assign lo = (b0 != upo_pkg::HDR_BYTE) ? b1 : b2;
    assign ck = (b0 != upo_pkg::HDR_BYTE) ? b2 : b3;

    // window as a shift chain, newest reading in entry 0; entries below the count are held
    logic [WINDOW_MAX-1:0][15:0] win_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] prev_sum_reg;
    logic [CW-1:0] prev_kept_reg;

    // per-request working registers
    upo_pkg::state_t state_reg, state_next;
    logic          ok_reg;
    logic [15:0]   raw_reg;
    logic [LW-1:0] step_reg;
    logic [SW-1:0] sum_reg;
    logic [CW-1:0] kept_reg, drop_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] quo_reg;
    logic [1:0]    cmp_ph_reg;
    logic [RW-1:0] lhs_reg;
    logic [RW-1:0] rhs_reg;
    logic [1:0]    c0_reg, c1_reg;

    // result register
    logic          out_v_reg;
    logic [15:0]   out_d_reg;
    logic [3:0]    out_u_reg;

    assign s_axis_tready = (state_reg == upo_pkg::ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;
    assign m_axis_tuser  = out_u_reg;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // cell row control and load image
    upo_pkg::cell_ctl_t ctl;
    logic [WINDOW_MAX-1:0][15:0] ld_val;
    logic [WINDOW_MAX-1:0]       ld_valid;
    logic [WINDOW_MAX-1:0][15:0] row_vals;

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            ld_val[i]   = win_reg[i];
            ld_valid[i] = (i < 32'(count_reg));
        end
    end

    upo_row #(.WINDOW_MAX(WINDOW_MAX)) u_row (
        .clk(clk), .ctl(ctl), .load_val(ld_val), .load_valid(ld_valid),
        .vals(row_vals)
    );

    // shared multiplier operand for the compare
    logic [RW-1:0] mul_a;
    logic [19:0]   thr_scaled;
    logic [SW-1:0] cmp_sum;
    logic [CW-1:0] cmp_kept;
    assign cmp_sum  = (cmp_ph_reg == 2'd0) ? sum_reg : prev_sum_reg;
    assign cmp_kept = (cmp_ph_reg == 2'd0) ? kept_reg : prev_kept_reg;

    logic [SW-1:0] eff_sum;
    logic [CW-1:0] eff_kept;
    assign eff_sum    = (cmp_kept == '0) ? '0 : cmp_sum;
    assign eff_kept   = (cmp_kept == '0) ? CW'(1) : cmp_kept;
    assign thr_scaled = 20'(thr_reg) * 20'(upo_pkg::DIST_DEN);
    assign mul_a      = RW'(thr_scaled) * RW'(eff_kept);

    logic [1:0] cmp_res;
    assign cmp_res = (lhs_reg < rhs_reg) ? CMP_BELOW :
                     ((lhs_reg > rhs_reg) ? CMP_ABOVE : CMP_EQ);

    // divide by three through the reciprocal 43/128, exact below 128
    logic [CW-1:0] tgt;
    logic [TW-1:0] tgt_prod;
    assign tgt_prod = TW'(eff_len) * TW'(43);
    assign tgt      = CW'(tgt_prod >> 7);

    // readings dropped from the low end: half the surplus, rounded up
    logic [CW:0] drop_sum;
    assign drop_sum = (CW+1)'(count_reg) - (CW+1)'(tgt) + (CW+1)'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ctl.load     = 1'b0;
        ctl.sort_en  = 1'b0;
        ctl.sort_odd = step_reg[0];
        case (state_reg)
            upo_pkg::ST_IDLE:
            begin
                if (acc)
                    state_next = upo_pkg::ST_LOAD;
            end
            upo_pkg::ST_LOAD:
            begin
                // push happens here, count trimmed to the window length
                if (ok_reg)
                begin
                    if (count_reg >= CW'(WINDOW_MAX))
                        count_next = CW'(WINDOW_MAX);
                    else
                        count_next = count_reg + CW'(1);
                    if (count_next > eff_len)
                        count_next = eff_len;
                end
                state_next = upo_pkg::ST_SORT;
            end
            upo_pkg::ST_SORT:
            begin
                if (step_reg == '0)
                    ctl.load = 1'b1;
                else
                    ctl.sort_en = 1'b1;
                if (32'(step_reg) == WINDOW_MAX + 1)
                    state_next = upo_pkg::ST_SUM;
            end
            upo_pkg::ST_SUM:
            begin
                if (32'(step_reg) >= 32'(kept_reg))
                    state_next = upo_pkg::ST_DIV;
            end
            upo_pkg::ST_DIV:
            begin
                if (32'(step_reg) == SW)
                    state_next = upo_pkg::ST_CMP;
            end
            upo_pkg::ST_CMP:
            begin
                if (cmp_ph_reg == 2'd3)
                    state_next = upo_pkg::ST_OUT;
            end
            upo_pkg::ST_OUT:
                state_next = upo_pkg::ST_IDLE;
            default:
                state_next = upo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upo_pkg::ST_IDLE;
            count_reg     <= '0;
            prev_sum_reg  <= '0;
            prev_kept_reg <= '0;
            out_v_reg     <= 1'b0;
            step_reg      <= '0;
            cmp_ph_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            if (state_reg == upo_pkg::ST_OUT)
                out_v_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                upo_pkg::ST_LOAD:
                    step_reg <= '0;
                upo_pkg::ST_SORT:
                    step_reg <= (state_next == upo_pkg::ST_SUM) ? '0 : step_reg + LW'(1);
                upo_pkg::ST_SUM:
                    step_reg <= (state_next == upo_pkg::ST_DIV) ? '0 : step_reg + LW'(1);
                upo_pkg::ST_DIV:
                    step_reg <= step_reg + LW'(1);
                upo_pkg::ST_CMP:
                    cmp_ph_reg <= cmp_ph_reg + 2'd1;
                upo_pkg::ST_OUT:
                begin
                    prev_sum_reg  <= sum_reg;
                    prev_kept_reg <= kept_reg;
                    cmp_ph_reg    <= '0;
                end
                default:
                    step_reg <= '0;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle from the top
    logic [DW-1:0] div_bit;
    assign div_bit = (32'(step_reg) < SW) ? DW'(SW - 1 - 32'(step_reg)) : '0;

    logic [SW-1:0] quo_next;
    logic [SW-1:0] rem_next;
    always_comb
    begin
        rem_next = {rem_reg[SW-2:0], sum_reg[div_bit]};
        quo_next = quo_reg;
        if (rem_next >= SW'(kept_reg))
        begin
            rem_next = rem_next - SW'(kept_reg);
            quo_next = {quo_reg[SW-2:0], 1'b1};
        end
        else
            quo_next = {quo_reg[SW-2:0], 1'b0};
    end

    logic full;
    logic changed;
    assign full = count_reg >= eff_len;
    assign changed = full && (((c0_reg == CMP_BELOW) && (c1_reg == CMP_ABOVE)) ||
                              ((c1_reg == CMP_BELOW) && (c0_reg == CMP_ABOVE)) ||
                              ((prev_sum_reg == '0) && (sum_reg != '0)));

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ok_reg  <= (8'(hi + lo) == 8'(ck + 8'd1));
            raw_reg <= {hi, lo};
        end
        if (state_reg == upo_pkg::ST_LOAD && ok_reg)
        begin
            win_reg[0] <= raw_reg;
            for (int i = 1; i < WINDOW_MAX; i++)
                win_reg[i] <= win_reg[i-1];
        end
        case (state_reg)
            upo_pkg::ST_SORT:
            begin
                sum_reg <= '0;
                if (eff_len > CW'(3) && count_reg > tgt)
                begin
                    kept_reg <= tgt;
                    drop_reg <= drop_sum[CW:1];
                end
                else
                begin
                    kept_reg <= count_reg;
                    drop_reg <= '0;
                end
            end
            upo_pkg::ST_SUM:
            begin
                if (32'(step_reg) < 32'(kept_reg))
                    sum_reg <= sum_reg + SW'(row_vals[IW'(32'(drop_reg) + 32'(step_reg))]);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            upo_pkg::ST_DIV:
            begin
                if (32'(step_reg) < SW)
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
            end
            upo_pkg::ST_CMP:
            begin
                if (cmp_ph_reg == 2'd0 || cmp_ph_reg == 2'd2)
                begin
                    lhs_reg <= RW'(eff_sum) * RW'(upo_pkg::DIST_NUM);
                    rhs_reg <= mul_a;
                end
                if (cmp_ph_reg == 2'd1)
                    c1_reg <= cmp_res;
                if (cmp_ph_reg == 2'd3)
                    c0_reg <= cmp_res;
            end
            upo_pkg::ST_OUT:
            begin
                out_d_reg <= (kept_reg == '0) ? 16'd0 : quo_reg[15:0];
                out_u_reg <= {changed && (c1_reg == CMP_BELOW), changed, full, ok_reg};
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == upo_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= WINDOW_MAX)
        else $error("count overflow");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg) == upo_pkg::ST_OUT)
        else $error("result without compute");
    a_kept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == upo_pkg::ST_DIV |-> kept_reg <= count_reg)
        else $error("kept too large");
`endif
endmodule
